@@ src/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define AST_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("assertion failed");

// property checked on every rising edge, reset included
`define AST_ANY(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

@@ src/mbcav_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbcav_pkg
// Types, widths, codes and the microcode table of the box clipping block.
// ----------------------------------------------------------------------------
package mbcav_pkg;

    // field widths
    localparam int EDGE_W  = 16;
    localparam int SPEED_W = 11;
    localparam int FAULT_W = 2;
    localparam int DELTA_W = EDGE_W + 1;
    localparam int PROD_W  = DELTA_W + SPEED_W;
    // magnitude of the product stays below 2^26
    localparam int DIV_W   = PROD_W - 1;
    localparam int REM_W   = SPEED_W - 1;
    localparam int CNT_W   = $clog2(DIV_W + 1);

    // pass limit
    localparam int MAX_PASSES = 8;
    localparam int PASS_W     = $clog2(MAX_PASSES + 1);

    // stream widths
    localparam int S_DATA_W = ((4 * EDGE_W + 2 * SPEED_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((4 * EDGE_W + FAULT_W + 7) / 8) * 8;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = EDGE_W;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIELD_LEFT   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIELD_TOP    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIELD_RIGHT  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIELD_BOTTOM = 2'd3;

    // fault codes
    localparam logic [FAULT_W-1:0] FAULT_NONE  = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_ZDIV  = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_LIMIT = 2'd2;

    // microcode
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE     = 3'd0;
    localparam step_t STEP_CHECK    = 3'd1;
    localparam step_t STEP_MUL      = 3'd2;
    localparam step_t STEP_DIV_INIT = 3'd3;
    localparam step_t STEP_DIV      = 3'd4;
    localparam step_t STEP_APPLY    = 3'd5;
    localparam step_t STEP_EMIT     = 3'd6;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_CHECK,
        OP_MUL,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_APPLY,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        CND_NEVER,
        CND_ALWAYS,
        CND_NO_ITEM,
        CND_STOP,
        CND_DIV_MORE,
        CND_OUT_BUSY
    } cond_t;

    // one control word: datapath op, jump condition, jump target, fall-through
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t tgt;
        step_t nxt;
    } uword_t;

    // control store
    function automatic uword_t ucode(input step_t pc);
        uword_t w;
        unique case (pc)
            STEP_IDLE:     w = '{OP_WAIT,     CND_NO_ITEM,  STEP_IDLE,  STEP_CHECK};
            STEP_CHECK:    w = '{OP_CHECK,    CND_STOP,     STEP_EMIT,  STEP_MUL};
            STEP_MUL:      w = '{OP_MUL,      CND_NEVER,    STEP_IDLE,  STEP_DIV_INIT};
            STEP_DIV_INIT: w = '{OP_DIV_INIT, CND_NEVER,    STEP_IDLE,  STEP_DIV};
            STEP_DIV:      w = '{OP_DIV_STEP, CND_DIV_MORE, STEP_DIV,   STEP_APPLY};
            STEP_APPLY:    w = '{OP_APPLY,    CND_ALWAYS,   STEP_CHECK, STEP_CHECK};
            STEP_EMIT:     w = '{OP_EMIT,     CND_OUT_BUSY, STEP_EMIT,  STEP_IDLE};
            default:       w = '{OP_WAIT,     CND_ALWAYS,   STEP_IDLE,  STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ src/moving_box_clip_along_velocity_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moving_box_clip_along_velocity_top
// Pushes a moving rectangle back inside the play field along its velocity.
// ----------------------------------------------------------------------------
// One item is worked at a time. At most MAX_PASSES corrections are made on
// an item, and the next item can be accepted once the previous result has
// been loaded into the output register. Each correction costs one check, one
// multiply, one divider setup, 27 steps of the one-bit restoring divider and
// one update. The next item is accepted while the previous result still waits
// in the output register. fault reads 0 when the box settled inside, 1 when a
// zero speed blocked the needed correction, 2 when the pass limit was reached.
module moving_box_clip_along_velocity_top
    import mbcav_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // box_left, box_top, box_right, box_bottom, speed_h, speed_v, zero pad
    input  logic [S_DATA_W-1:0]   s_tdata,
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_left, out_top, out_right, out_bottom, fault, zero pad
    output logic [M_DATA_W-1:0]   m_tdata,
    // configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // sequencer
    step_t pc_reg, pc_next;
    uword_t uw;

    // configuration
    logic signed [EDGE_W-1:0] fld_l_reg, fld_t_reg, fld_r_reg, fld_b_reg;

    // working box
    logic signed [EDGE_W-1:0]  l_reg, l_next, t_reg, t_next;
    logic signed [EDGE_W-1:0]  r_reg, r_next, b_reg, b_next;
    logic signed [SPEED_W-1:0] h_reg, h_next, v_reg, v_next;
    logic [PASS_W-1:0]         pass_reg, pass_next;

    // correction datapath
    logic                       horiz_reg, horiz_next;
    logic signed [DELTA_W-1:0]  delta_reg, delta_next;
    logic signed [SPEED_W-1:0]  num_reg, num_next, den_reg, den_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic [FAULT_W-1:0]         fault_reg, fault_next;
    logic                       neg_reg, neg_next;
    logic [DIV_W-1:0]           dvd_reg, dvd_next;
    logic [SPEED_W-1:0]         dsr_reg, dsr_next;
    logic [REM_W-1:0]           rem_reg, rem_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;

    // output register
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // check results
    logic                      in_viol, in_horiz, stop;
    logic signed [DELTA_W-1:0] in_delta;
    logic [FAULT_W-1:0]        in_fault;
    logic signed [SPEED_W-1:0] in_num, in_den;

    // divider scratch
    logic [SPEED_W-1:0]        trial;
    logic                      trial_ge;
    logic [PROD_W-1:0]         prod_mag;
    logic [EDGE_W-1:0]         quo;

    logic accept, out_busy, jump;

    assign uw       = ucode(pc_reg);
    assign s_tready = (uw.op == OP_WAIT);
    assign accept   = s_tvalid && s_tready;
    assign out_busy = m_tvalid_reg && !m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // edge check in left, right, top, bottom priority
    always_comb begin
        in_viol  = 1'b1;
        in_horiz = 1'b1;
        in_delta = '0;
        if (fld_l_reg > l_reg) begin
            in_delta = DELTA_W'($signed({fld_l_reg[EDGE_W-1], fld_l_reg})
                              - $signed({l_reg[EDGE_W-1], l_reg}));
        end else if (fld_r_reg < r_reg) begin
            in_delta = DELTA_W'($signed({fld_r_reg[EDGE_W-1], fld_r_reg})
                              - $signed({r_reg[EDGE_W-1], r_reg}));
        end else if (fld_t_reg > t_reg) begin
            in_horiz = 1'b0;
            in_delta = DELTA_W'($signed({fld_t_reg[EDGE_W-1], fld_t_reg})
                              - $signed({t_reg[EDGE_W-1], t_reg}));
        end else if (fld_b_reg < b_reg) begin
            in_horiz = 1'b0;
            in_delta = DELTA_W'($signed({fld_b_reg[EDGE_W-1], fld_b_reg})
                              - $signed({b_reg[EDGE_W-1], b_reg}));
        end else begin
            in_viol = 1'b0;
        end
        in_num = in_horiz ? v_reg : h_reg;
        in_den = in_horiz ? h_reg : v_reg;
        // limit is tested before the zero divisor
        if (!in_viol) begin
            in_fault = FAULT_NONE;
        end else if (pass_reg == PASS_W'(MAX_PASSES)) begin
            in_fault = FAULT_LIMIT;
        end else begin
            in_fault = FAULT_ZDIV;
        end
        stop = !in_viol || (pass_reg == PASS_W'(MAX_PASSES)) || (in_den == '0);
    end

    // divider step and quotient sign
    always_comb begin
        trial    = {rem_reg, dvd_reg[DIV_W-1]};
        trial_ge = (trial >= dsr_reg);
        prod_mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        quo      = neg_reg ? EDGE_W'(-dvd_reg[EDGE_W-1:0]) : dvd_reg[EDGE_W-1:0];
    end

    // jump decision
    always_comb begin
        case (uw.cond)
            CND_ALWAYS:   jump = 1'b1;
            CND_NO_ITEM:  jump = !accept;
            CND_STOP:     jump = stop;
            CND_DIV_MORE: jump = (cnt_reg != CNT_W'(1));
            CND_OUT_BUSY: jump = out_busy;
            default:      jump = 1'b0;
        endcase
        pc_next = jump ? uw.tgt : uw.nxt;
    end

    // datapath driven by the control word
    always_comb begin
        l_next        = l_reg;
        t_next        = t_reg;
        r_next        = r_reg;
        b_next        = b_reg;
        h_next        = h_reg;
        v_next        = v_reg;
        pass_next     = pass_reg;
        horiz_next    = horiz_reg;
        delta_next    = delta_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        prod_next     = prod_reg;
        fault_next    = fault_reg;
        neg_next      = neg_reg;
        dvd_next      = dvd_reg;
        dsr_next      = dsr_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        unique case (uw.op)
            OP_WAIT: begin
                if (accept) begin
                    l_next    = s_tdata[EDGE_W-1:0];
                    t_next    = s_tdata[2*EDGE_W-1:EDGE_W];
                    r_next    = s_tdata[3*EDGE_W-1:2*EDGE_W];
                    b_next    = s_tdata[4*EDGE_W-1:3*EDGE_W];
                    h_next    = s_tdata[4*EDGE_W+SPEED_W-1:4*EDGE_W];
                    v_next    = s_tdata[4*EDGE_W+2*SPEED_W-1:4*EDGE_W+SPEED_W];
                    pass_next = '0;
                end
            end
            OP_CHECK: begin
                horiz_next = in_horiz;
                delta_next = in_delta;
                num_next   = in_num;
                den_next   = in_den;
                fault_next = in_fault;
            end
            OP_MUL: begin
                prod_next = delta_reg * num_reg;
            end
            OP_DIV_INIT: begin
                neg_next = prod_reg[PROD_W-1] ^ den_reg[SPEED_W-1];
                dvd_next = prod_mag[DIV_W-1:0];
                dsr_next = den_reg[SPEED_W-1] ? SPEED_W'(-den_reg) : SPEED_W'(den_reg);
                rem_next = '0;
                cnt_next = CNT_W'(DIV_W);
            end
            OP_DIV_STEP: begin
                rem_next = trial_ge ? REM_W'(trial - dsr_reg) : REM_W'(trial);
                dvd_next = {dvd_reg[DIV_W-2:0], trial_ge};
                cnt_next = cnt_reg - CNT_W'(1);
            end
            OP_APPLY: begin
                if (horiz_reg) begin
                    l_next = l_reg + delta_reg[EDGE_W-1:0];
                    r_next = r_reg + delta_reg[EDGE_W-1:0];
                    t_next = t_reg + quo;
                    b_next = b_reg + quo;
                end else begin
                    l_next = l_reg + quo;
                    r_next = r_reg + quo;
                    t_next = t_reg + delta_reg[EDGE_W-1:0];
                    b_next = b_reg + delta_reg[EDGE_W-1:0];
                end
                pass_next = pass_reg + PASS_W'(1);
            end
            OP_EMIT: begin
                if (!out_busy) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_DATA_W'({fault_reg, b_reg, r_reg, t_reg, l_reg});
                end
            end
            default: begin
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= STEP_IDLE;
            m_tvalid_reg <= 1'b0;
            fld_l_reg    <= 16'sd0;
            fld_t_reg    <= 16'sd0;
            fld_r_reg    <= 16'sd639;
            fld_b_reg    <= 16'sd479;
        end else begin
            pc_reg       <= pc_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_FIELD_LEFT:   fld_l_reg <= cfg_wdata;
                    CFG_FIELD_TOP:    fld_t_reg <= cfg_wdata;
                    CFG_FIELD_RIGHT:  fld_r_reg <= cfg_wdata;
                    CFG_FIELD_BOTTOM: fld_b_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        l_reg       <= l_next;
        t_reg       <= t_next;
        r_reg       <= r_next;
        b_reg       <= b_next;
        h_reg       <= h_next;
        v_reg       <= v_next;
        pass_reg    <= pass_next;
        horiz_reg   <= horiz_next;
        delta_reg   <= delta_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        prod_reg    <= prod_next;
        fault_reg   <= fault_next;
        neg_reg     <= neg_next;
        dvd_reg     <= dvd_next;
        dsr_reg     <= dsr_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

@@ src/mbcav_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbcav_chk
// Port-level checks on the box clipping block, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbcav_chk
    import mbcav_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // a stalled result holds its value
    `AST_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // one item in work at a time: no acceptance right after one
    `AST_CLK(a_one_item, aclk, aresetn, s_tvalid && s_tready |=> !s_tready)

    // fault code never goes past the pass limit code
    `AST_CLK(a_fault_code, aclk, aresetn, m_tvalid |-> m_tdata[4*EDGE_W +: FAULT_W] <= FAULT_LIMIT)

    // reset leaves no result pending
    `AST_ANY(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

endmodule

bind moving_box_clip_along_velocity_top mbcav_chk u_mbcav_chk (.*);

@@ bench/moving_box_clip_along_velocity_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moving_box_clip_along_velocity_top_test
// Self-checking bench for the box clipping block. A table of directed boxes is
// sent first: edge cases, zero speeds, pass limit, field and speed extremes.
// Random boxes follow under several play field settings, with the sender and
// the receiver idling at random and one long receiver hold-off. Every result
// item is checked field by field against its table value or an in-bench model
// of the clipping passes.
// ----------------------------------------------------------------------------
module moving_box_clip_along_velocity_top_test;
    import mbcav_pkg::*;

    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int HOLD_CYCLES     = 1500;
    localparam int DRAIN_CYCLES    = 300;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int NUM_DIRECTED    = 22;
    localparam int NUM_PHASES      = 8;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic signed [EDGE_W-1:0]  left;
        logic signed [EDGE_W-1:0]  top;
        logic signed [EDGE_W-1:0]  right;
        logic signed [EDGE_W-1:0]  bottom;
        logic signed [SPEED_W-1:0] sh;
        logic signed [SPEED_W-1:0] sv;
    } box_item_t;

    typedef struct packed {
        logic signed [EDGE_W-1:0] left;
        logic signed [EDGE_W-1:0] top;
        logic signed [EDGE_W-1:0] right;
        logic signed [EDGE_W-1:0] bottom;
        logic [FAULT_W-1:0]       fault;
    } clip_result_t;

    typedef struct packed {
        box_item_t    item;
        logic         typed;
        clip_result_t want;
    } directed_row_t;

    typedef struct packed {
        int   fl;
        int   ft;
        int   fr;
        int   fb;
        int   tx_pct;
        int   rx_pct;
        logic hold;
    } phase_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // box_left, box_top, box_right, box_bottom, speed_h, speed_v, zero pad
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // out_left, out_top, out_right, out_bottom, fault, zero pad
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // copy of the play field registers
    int fld_left   = 0;
    int fld_top    = 0;
    int fld_right  = 639;
    int fld_bottom = 479;

    clip_result_t clipped_boxes_due[$];
    int           mismatch_count = 0;
    int unsigned  cycle_count = 0;
    int           tx_idle_pct = 0;
    int           rx_stall_pct = 0;
    logic         hold_active = 1'b0;
    event         rx_hold;

    // directed boxes, checked against the reset field (0, 0, 639, 479)
    directed_row_t directed_rows [NUM_DIRECTED] = '{
        '{'{10, 20, 100, 200, 5, 3}, 1'b1, '{10, 20, 100, 200, FAULT_NONE}},
        '{'{-10, 0, 50, 50, 0, 5}, 1'b1, '{-10, 0, 50, 50, FAULT_ZDIV}},
        '{'{10, -5, 50, 50, 3, 0}, 1'b1, '{10, -5, 50, 50, FAULT_ZDIV}},
        '{'{600, 10, 700, 50, 0, 7}, 1'b1, '{600, 10, 700, 50, FAULT_ZDIV}},
        '{'{10, 400, 50, 500, 4, 0}, 1'b1, '{10, 400, 50, 500, FAULT_ZDIV}},
        '{'{-10, 10, 40, 60, 2, 1}, 1'b1, '{0, 15, 50, 65, FAULT_NONE}},
        '{'{-3, 10, 40, 60, 2, -1}, 1'b1, '{0, 9, 43, 59, FAULT_NONE}},
        '{'{600, 100, 650, 200, 4, -2}, 1'b1, '{589, 105, 639, 205, FAULT_NONE}},
        '{'{100, -7, 200, 50, 3, 2}, 1'b1, '{110, 0, 210, 57, FAULT_NONE}},
        '{'{100, 470, 200, 490, -5, 3}, 1'b1, '{118, 459, 218, 479, FAULT_NONE}},
        '{'{0, 0, 639, 479, 0, 0}, 1'b1, '{0, 0, 639, 479, FAULT_NONE}},
        '{'{300, 300, 100, 100, 0, 0}, 1'b1, '{300, 300, 100, 100, FAULT_NONE}},
        '{'{-10, 10, 700, 20, 1, 0}, 1'b1, '{-71, 10, 639, 20, FAULT_LIMIT}},
        '{'{-32768, -32768, -32768, -32768, -1024, -1024}, 1'b0, '0},
        '{'{32767, 32767, 32767, 32767, 1023, 1023}, 1'b0, '0},
        '{'{-32768, 0, 32767, 10, 1, 1023}, 1'b0, '0},
        '{'{-100, -100, 1000, 1000, 1, 1}, 1'b0, '0},
        '{'{-1, 0, 10, 10, -1024, 1023}, 1'b0, '0},
        '{'{700, 500, 800, 600, -3, -7}, 1'b0, '0},
        '{'{-5, -5, 5, 5, -1, -1}, 1'b0, '0},
        '{'{21845, -21846, 21845, -21846, 682, -683}, 1'b0, '0},
        '{'{-21846, 21845, -21846, 21845, -683, 682}, 1'b0, '0}
    };

    // field settings and idling per random phase
    phase_t phases [NUM_PHASES] = '{
        '{0, 0, 639, 479, 0, 0, 1'b0},
        '{-200, -150, 200, 150, 45, 0, 1'b0},
        '{-32768, -32768, 32767, 32767, 0, 45, 1'b0},
        '{100, 100, 101, 101, 16, 16, 1'b0},
        '{500, 400, 100, 50, 0, 0, 1'b1},
        '{32767, 32767, -32768, -32768, 45, 0, 1'b0},
        '{-32768, 0, 639, 32767, 0, 45, 1'b0},
        '{-1000, -20, 3000, 40, 16, 16, 1'b0}
    };

    moving_box_clip_along_velocity_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // wrap to a 16-bit edge, sign extended
    function automatic int wrap16(input longint x);
        logic signed [EDGE_W-1:0] w;
        w = x[EDGE_W-1:0];
        return int'(w);
    endfunction

    // clipping passes: one correction per pass, left, right, top, bottom
    function automatic clip_result_t predict_clip(input box_item_t it);
        clip_result_t res;
        int           l, t, r, b, h, v, pass;
        longint       delta, shift;
        logic         horiz, done;
        l = it.left;
        t = it.top;
        r = it.right;
        b = it.bottom;
        h = it.sh;
        v = it.sv;
        res.fault = FAULT_LIMIT;
        done = 1'b0;
        horiz = 1'b0;
        delta = 0;
        for (pass = 0; pass <= MAX_PASSES && !done; pass++) begin
            if (fld_left > l) begin
                horiz = 1'b1;
                delta = longint'(fld_left) - l;
            end else if (fld_right < r) begin
                horiz = 1'b1;
                delta = longint'(fld_right) - r;
            end else if (fld_top > t) begin
                horiz = 1'b0;
                delta = longint'(fld_top) - t;
            end else if (fld_bottom < b) begin
                horiz = 1'b0;
                delta = longint'(fld_bottom) - b;
            end else begin
                res.fault = FAULT_NONE;
                done = 1'b1;
            end
            // still outside after the last allowed correction
            if (!done && pass == MAX_PASSES) begin
                res.fault = FAULT_LIMIT;
                done = 1'b1;
            end
            // the needed divisor is a zero speed
            if (!done && ((horiz && h == 0) || (!horiz && v == 0))) begin
                res.fault = FAULT_ZDIV;
                done = 1'b1;
            end
            if (!done) begin
                if (horiz) begin
                    shift = (delta * v) / h;
                    l = wrap16(l + delta);
                    r = wrap16(r + delta);
                    t = wrap16(t + shift);
                    b = wrap16(b + shift);
                end else begin
                    shift = (delta * h) / v;
                    l = wrap16(l + shift);
                    r = wrap16(r + shift);
                    t = wrap16(t + delta);
                    b = wrap16(b + delta);
                end
            end
        end
        res.left = EDGE_W'(l);
        res.top = EDGE_W'(t);
        res.right = EDGE_W'(r);
        res.bottom = EDGE_W'(b);
        return res;
    endfunction

    // speed mix: zero, any value, extremes, small
    function automatic logic signed [SPEED_W-1:0] random_speed();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return SPEED_W'($urandom);
        end else if (pick == 2) begin
            case ($urandom_range(0, 3))
                0: return SPEED_W'(-1024);
                1: return SPEED_W'(1023);
                2: return SPEED_W'(-1);
                default: return SPEED_W'(1);
            endcase
        end
        return SPEED_W'(int'($urandom_range(0, 40)) - 20);
    endfunction

    // mostly boxes near a field edge, some pure noise
    function automatic box_item_t random_box();
        box_item_t it;
        int        kind, bw, bh, x0, y0;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            it.left = EDGE_W'($urandom);
            it.top = EDGE_W'($urandom);
            it.right = EDGE_W'($urandom);
            it.bottom = EDGE_W'($urandom);
            it.sh = SPEED_W'($urandom);
            it.sv = SPEED_W'($urandom);
        end else begin
            bw = (kind == 9) ? int'($urandom_range(0, 2000)) : int'($urandom_range(0, 120));
            bh = (kind == 9) ? int'($urandom_range(0, 2000)) : int'($urandom_range(0, 120));
            x0 = ($urandom_range(0, 1) ? fld_left : fld_right - bw)
                 + int'($urandom_range(0, 160)) - 80;
            y0 = ($urandom_range(0, 1) ? fld_top : fld_bottom - bh)
                 + int'($urandom_range(0, 160)) - 80;
            it.left = EDGE_W'(x0);
            it.right = EDGE_W'(x0 + bw);
            it.top = EDGE_W'(y0);
            it.bottom = EDGE_W'(y0 + bh);
            it.sh = random_speed();
            it.sv = random_speed();
        end
        return it;
    endfunction

    // compare one result item with the oldest clipped box due
    function automatic void check_result(input logic [M_DATA_W-1:0] data);
        clip_result_t got, want;
        got.left = data[0*EDGE_W +: EDGE_W];
        got.top = data[1*EDGE_W +: EDGE_W];
        got.right = data[2*EDGE_W +: EDGE_W];
        got.bottom = data[3*EDGE_W +: EDGE_W];
        got.fault = data[4*EDGE_W +: FAULT_W];
        if (clipped_boxes_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("unexpected item: %0d %0d %0d %0d fault %0d",
                         got.left, got.top, got.right, got.bottom, got.fault);
        end else begin
            want = clipped_boxes_due.pop_front();
            if (got.left !== want.left || got.top !== want.top ||
                got.right !== want.right || got.bottom !== want.bottom ||
                got.fault !== want.fault) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("mismatch: expected %0d %0d %0d %0d fault %0d,",
                             want.left, want.top, want.right, want.bottom, want.fault,
                             " got %0d %0d %0d %0d fault %0d",
                             got.left, got.top, got.right, got.bottom, got.fault);
            end
        end
    endfunction

    // offer one box, record its clipped result once accepted
    task automatic send_box(input box_item_t it, input logic typed,
                            input clip_result_t want);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= S_DATA_W'({it.sv, it.sh, it.bottom, it.right, it.top, it.left});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        clipped_boxes_due.push_back(typed ? want : predict_clip(it));
    endtask

    // write all four field registers, one per cycle
    task automatic set_field(input int fl, input int ft, input int fr, input int fb);
        cfg_wr_en <= 1'b1;
        cfg_addr <= CFG_FIELD_LEFT;
        cfg_wdata <= CFG_DATA_W'(fl);
        @(posedge aclk);
        cfg_addr <= CFG_FIELD_TOP;
        cfg_wdata <= CFG_DATA_W'(ft);
        @(posedge aclk);
        cfg_addr <= CFG_FIELD_RIGHT;
        cfg_wdata <= CFG_DATA_W'(fr);
        @(posedge aclk);
        cfg_addr <= CFG_FIELD_BOTTOM;
        cfg_wdata <= CFG_DATA_W'(fb);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        fld_left = wrap16(fl);
        fld_top = wrap16(ft);
        fld_right = wrap16(fr);
        fld_bottom = wrap16(fb);
    endtask

    // wait until every clipped box due has come back
    task automatic wait_drained();
        while (clipped_boxes_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // receiver: check accepted items, stall at random or while held off
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                check_result(m_tdata);
            m_tready <= aresetn && !hold_active && ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // long receiver hold-off, counted here
    initial begin
        forever begin
            @(rx_hold);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            hold_active <= 1'b0;
        end
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // stimulus
    initial begin
        int row;
        int ph;
        int n;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table on the reset field
        for (row = 0; row < NUM_DIRECTED; row++)
            send_box(directed_rows[row].item, directed_rows[row].typed,
                     directed_rows[row].want);
        s_tvalid <= 1'b0;

        // random phases, field rewritten while idle
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            set_field(phases[ph].fl, phases[ph].ft, phases[ph].fr, phases[ph].fb);
            tx_idle_pct = phases[ph].tx_pct;
            rx_stall_pct <= phases[ph].rx_pct;
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phases[ph].hold && n == 10)
                    -> rx_hold;
                send_box(random_box(), 1'b0, '0);
            end
            s_tvalid <= 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && clipped_boxes_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
